// ===== src/point_in_sky_box_defines.svh =====
// Assertion macros shared by the sky box RTL.
// Depends on nothing; the using module must have clk and rst_n in scope.
`ifndef POINT_IN_SKY_BOX_DEFINES_SVH
`define POINT_IN_SKY_BOX_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PSB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PSB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/psb_pkg.sv =====
// Package for the sky box point test: verdict codes and numeric constants.
// Depends on nothing.
package psb_pkg;

  // Default angle format: signed degrees with a binary fraction.
  localparam int ANGLE_WIDTH_DEF     = 40;
  localparam int ANGLE_FRAC_BITS_DEF = 20;

  // One null flag per angle operand.
  localparam int NUM_OPERANDS = 6;

  // 360 degrees is 45 * 2^(F+3); the 45 part is reduced separately.
  localparam int LOW_SHIFT_EXTRA = 3;
  localparam int MOD_BASE        = 45;
  localparam int MOD_BITS        = 6;

  // 2^12 is 1 modulo 45, so 12-bit chunks can simply be summed.
  localparam int CHUNK_BITS = 12;
  localparam int SUM_BITS   = 16;
  localparam int FOLD_BITS  = 13;

  // floor(2^18 / 45): quotient estimate is low by at most one.
  localparam int MOD_RECIP       = 5825;
  localparam int MOD_RECIP_SHIFT = 18;
  localparam int PROD_BITS       = 26;

  typedef enum logic [1:0] {
    VERDICT_OUTSIDE = 2'd0,
    VERDICT_INSIDE  = 2'd1,
    VERDICT_NULL    = 2'd2
  } verdict_t;

endpackage

// ===== src/psb_if.sv =====
// Valid/ready channels for the sky box test: the item channel and the verdict channel.
// Depends on psb_pkg for the default angle width and operand count.
interface psb_in_if #(
  parameter int ANGLE_WIDTH = psb_pkg::ANGLE_WIDTH_DEF
) ();
  logic                                valid;
  logic                                ready;
  logic signed [ANGLE_WIDTH-1:0]       pos_ra;
  logic signed [ANGLE_WIDTH-1:0]       pos_dec;
  logic signed [ANGLE_WIDTH-1:0]       box_ra_low;
  logic signed [ANGLE_WIDTH-1:0]       box_dec_low;
  logic signed [ANGLE_WIDTH-1:0]       box_ra_high;
  logic signed [ANGLE_WIDTH-1:0]       box_dec_high;
  logic [psb_pkg::NUM_OPERANDS-1:0]    null_mask;

  modport source (
    output valid, pos_ra, pos_dec, box_ra_low, box_dec_low, box_ra_high,
           box_dec_high, null_mask,
    input  ready
  );
  modport sink (
    input  valid, pos_ra, pos_dec, box_ra_low, box_dec_low, box_ra_high,
           box_dec_high, null_mask,
    output ready
  );
endinterface

interface psb_out_if ();
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface

// ===== src/psb_wrap.sv =====
// Reduces a signed angle modulo 360 degrees into [0, 360).
// Depends on psb_pkg for the chunk-folding and reciprocal constants.
module psb_wrap #(
  parameter int CW = 41,
  parameter int F  = psb_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic signed [CW-1:0] angle,
  output logic [F+8:0]         wrapped
);
  localparam int SH  = F + psb_pkg::LOW_SHIFT_EXTRA;
  localparam int QW  = CW - SH;
  localparam int NCH = (QW + psb_pkg::CHUNK_BITS - 1) / psb_pkg::CHUNK_BITS;
  localparam int EW  = NCH * psb_pkg::CHUNK_BITS;
  localparam int CB  = psb_pkg::CHUNK_BITS;
  localparam int SB  = psb_pkg::SUM_BITS;
  localparam int FB  = psb_pkg::FOLD_BITS;
  localparam int PB  = psb_pkg::PROD_BITS;
  localparam int MB  = psb_pkg::MOD_BITS;

  logic signed [QW-1:0] q_hi;
  logic [EW-1:0]        q_ext;
  logic [SB-1:0]        chunk_sum;
  logic [FB-1:0]        folded;
  logic [PB-1:0]        prod;
  logic [FB-1:0]        quo;
  logic [FB-1:0]        rem_est;
  logic [FB-1:0]        rem;

  // Upper part counts multiples of 2^(F+3); only its value modulo 45 matters.
  assign q_hi  = angle[CW-1:SH];
  assign q_ext = EW'(q_hi);

  // Sum the 12-bit chunks; the two's complement weight of the sign is -1 mod 45,
  // which is the same as adding 44.
  always_comb begin
    chunk_sum = q_hi[QW-1] ? SB'(psb_pkg::MOD_BASE - 1) : '0;
    for (int i = 0; i < NCH; i++) begin
      chunk_sum = chunk_sum + SB'(q_ext[i*CB +: CB]);
    end
  end

  // Fold once more, then divide by 45 with a reciprocal and one correction.
  assign folded  = FB'(chunk_sum[CB-1:0]) + FB'(chunk_sum[SB-1:CB]);
  assign prod    = PB'(folded) * PB'(psb_pkg::MOD_RECIP);
  assign quo     = FB'(prod >> psb_pkg::MOD_RECIP_SHIFT);
  assign rem_est = folded - FB'(quo * FB'(psb_pkg::MOD_BASE));
  assign rem     = (rem_est >= FB'(psb_pkg::MOD_BASE)) ?
                   rem_est - FB'(psb_pkg::MOD_BASE) : rem_est;

  // The low bits are already below 2^(F+3) and pass straight through.
  assign wrapped = {rem[MB-1:0], angle[SH-1:0]};
endmodule

// ===== src/psb_judge.sv =====
// Combinational verdict for one registered item: range checks and box test.
// Depends on psb_pkg for verdict codes and on psb_wrap for the 360 reduction.
module psb_judge #(
  parameter int ANGLE_WIDTH     = psb_pkg::ANGLE_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = psb_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic signed [ANGLE_WIDTH-1:0]    pos_ra,
  input  logic signed [ANGLE_WIDTH-1:0]    pos_dec,
  input  logic signed [ANGLE_WIDTH-1:0]    box_ra_low,
  input  logic signed [ANGLE_WIDTH-1:0]    box_dec_low,
  input  logic signed [ANGLE_WIDTH-1:0]    box_ra_high,
  input  logic signed [ANGLE_WIDTH-1:0]    box_dec_high,
  input  logic [psb_pkg::NUM_OPERANDS-1:0] null_mask,
  output psb_pkg::verdict_t                verdict
);
  localparam int W  = ANGLE_WIDTH;
  localparam int F  = ANGLE_FRAC_BITS;
  // Wide enough for the angles and for the 360 degree constant, signed.
  localparam int CW = ((W > F + 10) ? W : F + 10) + 1;
  localparam int RW = F + 9;

  localparam logic signed [CW-1:0] DEG_90  = CW'(64'd90 << F);
  localparam logic signed [CW-1:0] DEG_360 = CW'(64'd360 << F);

  logic signed [CW-1:0] ra, dec, ra_lo, dec_lo, ra_hi, dec_hi;
  logic signed [CW:0]   span;
  logic [RW-1:0]        p_w, lo_w, hi_w;
  logic                 dec_bad, reversed, rev_bad, band_miss, full, hit;

  assign ra     = CW'(pos_ra);
  assign dec    = CW'(pos_dec);
  assign ra_lo  = CW'(box_ra_low);
  assign dec_lo = CW'(box_dec_low);
  assign ra_hi  = CW'(box_ra_high);
  assign dec_hi = CW'(box_dec_high);

  // Declinations must lie in [-90, 90].
  assign dec_bad = (dec < -DEG_90) || (dec > DEG_90) ||
                   (dec_lo < -DEG_90) || (dec_lo > DEG_90) ||
                   (dec_hi < -DEG_90) || (dec_hi > DEG_90);

  // A reversed box is only legal when both ends already lie in [0, 360].
  assign reversed = ra_hi < ra_lo;
  assign rev_bad  = reversed && ((ra_hi < 0) || (ra_lo > DEG_360));

  assign band_miss = (dec_lo > dec_hi) || (dec < dec_lo) || (dec > dec_hi);

  // A span of a full turn or more covers every right ascension.
  assign span = (CW+1)'(ra_hi) - (CW+1)'(ra_lo);
  assign full = !reversed && (span >= (CW+1)'(DEG_360));

  psb_wrap #(.CW(CW), .F(F)) u_wrap_pos (.angle(ra),    .wrapped(p_w));
  psb_wrap #(.CW(CW), .F(F)) u_wrap_lo  (.angle(ra_lo), .wrapped(lo_w));
  psb_wrap #(.CW(CW), .F(F)) u_wrap_hi  (.angle(ra_hi), .wrapped(hi_w));

  // Ordered box is an interval; otherwise it wraps through zero.
  assign hit = (lo_w <= hi_w) ? ((p_w >= lo_w) && (p_w <= hi_w))
                              : ((p_w >= lo_w) || (p_w <= hi_w));

  // Priority follows the checks: nulls and bad arguments first.
  always_comb begin
    if (null_mask != '0 || dec_bad || rev_bad) begin
      verdict = psb_pkg::VERDICT_NULL;
    end else if (band_miss) begin
      verdict = psb_pkg::VERDICT_OUTSIDE;
    end else if (full || hit) begin
      verdict = psb_pkg::VERDICT_INSIDE;
    end else begin
      verdict = psb_pkg::VERDICT_OUTSIDE;
    end
  end
endmodule

// ===== src/point_in_sky_box.sv =====
// Sky box point test, top level: item register, verdict logic and result register.
// Depends on psb_pkg, psb_if, psb_judge and point_in_sky_box_defines.svh.
//
// Each transfer on in_ch carries a sky position, a right ascension/declination
// box and per-operand null flags; exactly one verdict per item leaves on out_ch
// in the order the items came in (0 outside, 1 inside, 2 null or invalid).
// The block takes one item every clock cycle while in_ch.ready is high. Each verdict
// passes through the item register and then the result register, with the range
// checks and three modulo-360 reductions in between.
// in_ch.ready drops only when both registers hold items and out_ch is stalled.
`include "point_in_sky_box_defines.svh"

module point_in_sky_box #(
  parameter int ANGLE_WIDTH     = psb_pkg::ANGLE_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = psb_pkg::ANGLE_FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  psb_in_if.sink      in_ch,
  psb_out_if.source   out_ch
);
  localparam int W = ANGLE_WIDTH;

  logic                             s1_v_r, s1_v_nxt;
  logic signed [W-1:0]              pos_ra_r, pos_dec_r, box_ra_low_r, box_dec_low_r;
  logic signed [W-1:0]              box_ra_high_r, box_dec_high_r;
  logic [psb_pkg::NUM_OPERANDS-1:0] null_mask_r;
  logic                             out_v_r, out_v_nxt;
  psb_pkg::verdict_t                verdict_r, verdict_nxt;
  logic                             out_adv;
  logic                             in_load;

  // The result register moves when it is empty or its item transfers out.
  assign out_adv  = !out_v_r || out_ch.ready;
  assign in_load  = !s1_v_r || out_adv;
  assign in_ch.ready = in_load;

  assign s1_v_nxt  = in_load ? in_ch.valid : s1_v_r;
  assign out_v_nxt = out_adv ? s1_v_r : out_v_r;

  // Valid bits of the item register and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Item register payload, loaded on each input transfer.
  always_ff @(posedge clk) begin
    if (in_load && in_ch.valid) begin
      pos_ra_r       <= in_ch.pos_ra;
      pos_dec_r      <= in_ch.pos_dec;
      box_ra_low_r   <= in_ch.box_ra_low;
      box_dec_low_r  <= in_ch.box_dec_low;
      box_ra_high_r  <= in_ch.box_ra_high;
      box_dec_high_r <= in_ch.box_dec_high;
      null_mask_r    <= in_ch.null_mask;
    end
  end

  psb_judge #(
    .ANGLE_WIDTH     (ANGLE_WIDTH),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_judge (
    .pos_ra       (pos_ra_r),
    .pos_dec      (pos_dec_r),
    .box_ra_low   (box_ra_low_r),
    .box_dec_low  (box_dec_low_r),
    .box_ra_high  (box_ra_high_r),
    .box_dec_high (box_dec_high_r),
    .null_mask    (null_mask_r),
    .verdict      (verdict_nxt)
  );

  // Result register payload.
  always_ff @(posedge clk) begin
    if (out_adv && s1_v_r) begin
      verdict_r <= verdict_nxt;
    end
  end

  assign out_ch.valid   = out_v_r;
  assign out_ch.verdict = verdict_r;

  // A full pipeline with a stalled output must not take another item.
  `PSB_ASSERT_IMP(a_full_stall_blocks, s1_v_r && out_v_r && !out_ch.ready,
                  !in_ch.ready, "item taken while pipeline full and stalled")
  // An item in the first register moves to the result register when it frees.
  `PSB_ASSERT_NXT(a_item_advances, s1_v_r && out_adv, out_v_r,
                  "item lost between registers")
  // Any null flag forces the null verdict.
  `PSB_ASSERT_NXT(a_null_flag_null, s1_v_r && out_adv && (null_mask_r != '0),
                  out_v_r && (verdict_r == psb_pkg::VERDICT_NULL),
                  "null operand not reported as null")
  // With no new item and an idle output, the first register drains.
  `PSB_ASSERT_NXT(a_drain, !in_ch.valid && !out_v_r, !s1_v_r,
                  "item register did not drain")
endmodule

// ===== tb/point_in_sky_box_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for point_in_sky_box: a queue-fed driver, a monitor
// and a verdict predictor for the sky box test. Depends on psb_pkg and psb_if.
module point_in_sky_box_test;

  localparam int    AW          = psb_pkg::ANGLE_WIDTH_DEF;
  localparam int    NOPS        = psb_pkg::NUM_OPERANDS;
  localparam longint ONE_DEGREE  = longint'(1) << psb_pkg::ANGLE_FRAC_BITS_DEF;
  localparam longint FULL_CIRCLE = 360 * ONE_DEGREE;
  localparam longint RIGHT_ANGLE = 90 * ONE_DEGREE;
  localparam longint ANGLE_MAX   = (longint'(1) << (AW - 1)) - 1;
  localparam longint ANGLE_MIN   = -(longint'(1) << (AW - 1));

  typedef struct {
    logic signed [AW-1:0]       ra;
    logic signed [AW-1:0]       dec;
    logic signed [AW-1:0]       ra_lo;
    logic signed [AW-1:0]       dec_lo;
    logic signed [AW-1:0]       ra_hi;
    logic signed [AW-1:0]       dec_hi;
    logic [NOPS-1:0]            nulls;
  } sky_query_t;

  logic clk;
  logic rst_n;

  psb_in_if #(.ANGLE_WIDTH(AW)) in_ch ();
  psb_out_if out_ch ();

  point_in_sky_box #(
    .ANGLE_WIDTH    (AW),
    .ANGLE_FRAC_BITS(psb_pkg::ANGLE_FRAC_BITS_DEF)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  sky_query_t         query_q[$];
  psb_pkg::verdict_t  verdict_q[$];
  int send_idle = 18;
  int recv_idle = 58;
  int error_count = 0;
  int n_in_box = 0;
  int n_out_box = 0;
  int n_invalid = 0;

  // Clock and the single reset at the start of the run.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Remainder modulo 360 degrees, made non-negative.
  function automatic longint wrap_circle(longint a);
    longint r;
    r = a % FULL_CIRCLE;
    if (r < 0) r += FULL_CIRCLE;
    return r;
  endfunction

  function automatic bit dec_out_of_range(longint d);
    return d < -RIGHT_ANGLE || d > RIGHT_ANGLE;
  endfunction

  // Expected verdict of one query.
  function automatic psb_pkg::verdict_t predict_verdict(sky_query_t q);
    longint ra, dec, ra_lo, dec_lo, ra_hi, dec_hi, pt, lo, hi;
    bit covers_all;
    bit hit;
    ra = longint'(q.ra);
    dec = longint'(q.dec);
    ra_lo = longint'(q.ra_lo);
    dec_lo = longint'(q.dec_lo);
    ra_hi = longint'(q.ra_hi);
    dec_hi = longint'(q.dec_hi);
    if (q.nulls != '0) return psb_pkg::VERDICT_NULL;
    if (dec_out_of_range(dec) || dec_out_of_range(dec_lo) || dec_out_of_range(dec_hi))
      return psb_pkg::VERDICT_NULL;
    if (ra_hi < ra_lo && (ra_hi < 0 || ra_lo > FULL_CIRCLE)) return psb_pkg::VERDICT_NULL;
    if (dec_lo > dec_hi || dec < dec_lo || dec > dec_hi) return psb_pkg::VERDICT_OUTSIDE;
    pt = wrap_circle(ra);
    covers_all = (ra_hi >= ra_lo) && (ra_hi - ra_lo >= FULL_CIRCLE);
    if (covers_all) begin
      lo = 0;
      hi = FULL_CIRCLE;
    end else begin
      lo = wrap_circle(ra_lo);
      hi = wrap_circle(ra_hi);
    end
    if (lo <= hi) hit = (pt >= lo && pt <= hi);
    else hit = (pt >= lo || pt <= hi);
    return hit ? psb_pkg::VERDICT_INSIDE : psb_pkg::VERDICT_OUTSIDE;
  endfunction

  function automatic longint deg(int d);
    return longint'(d) * ONE_DEGREE;
  endfunction

  function automatic sky_query_t make_query(longint ra, longint dec, longint ra_lo,
                                            longint dec_lo, longint ra_hi,
                                            longint dec_hi, int nulls);
    sky_query_t q;
    q.ra = ra[AW-1:0];
    q.dec = dec[AW-1:0];
    q.ra_lo = ra_lo[AW-1:0];
    q.dec_lo = dec_lo[AW-1:0];
    q.ra_hi = ra_hi[AW-1:0];
    q.dec_hi = dec_hi[AW-1:0];
    q.nulls = nulls[NOPS-1:0];
    return q;
  endfunction

  // Uniform value in [lo, hi].
  function automatic longint rand_between(longint lo, longint hi);
    longint unsigned span, r;
    span = longint'(hi - lo) + 1;
    r = {$urandom, $urandom};
    return lo + longint'(r % span);
  endfunction

  function automatic longint rand_raw_angle();
    longint unsigned r;
    r = {$urandom, $urandom};
    return longint'(r[AW-1:0]) - ((r[AW-1]) ? (longint'(1) << AW) : 0);
  endfunction

  // Right ascension: mostly a few turns either way, some near multiples of 360.
  function automatic longint rand_ra();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return rand_raw_angle();
    if (pick < 4)
      return (longint'($urandom_range(0, 6)) - 3) * FULL_CIRCLE +
             longint'($urandom_range(0, 4)) - 2;
    return rand_between(-2 * FULL_CIRCLE, 2 * FULL_CIRCLE);
  endfunction

  // Declination: mostly legal, some on the poles and some anywhere.
  function automatic longint rand_dec();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return rand_raw_angle();
    if (pick == 1)
      return ($urandom_range(0, 1) ? RIGHT_ANGLE : -RIGHT_ANGLE) +
             longint'($urandom_range(0, 2)) - 1;
    return rand_between(-RIGHT_ANGLE, RIGHT_ANGLE);
  endfunction

  // Random query, mostly well formed with a fair share landing inside the box.
  function automatic sky_query_t random_query();
    longint ra, dec, ra_lo, dec_lo, ra_hi, dec_hi, swap_tmp;
    int nulls;
    nulls = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 63) : 0;
    dec_lo = rand_dec();
    dec_hi = rand_dec();
    if ($urandom_range(0, 4) != 0 && dec_lo > dec_hi) begin
      swap_tmp = dec_lo;
      dec_lo = dec_hi;
      dec_hi = swap_tmp;
    end
    if (dec_lo <= dec_hi && $urandom_range(0, 9) < 7) dec = rand_between(dec_lo, dec_hi);
    else dec = rand_dec();
    ra_lo = rand_ra();
    if ($urandom_range(0, 3) != 0)
      ra_hi = ra_lo + rand_between(0, FULL_CIRCLE + FULL_CIRCLE / 4);
    else ra_hi = rand_ra();
    if (ra_lo <= ra_hi && $urandom_range(0, 1) == 1) ra = rand_between(ra_lo, ra_hi);
    else ra = rand_ra();
    return make_query(ra, dec, ra_lo, dec_lo, ra_hi, dec_hi, nulls);
  endfunction

  // Driver: presents the next pending query, holding it until the transfer.
  always @(posedge clk) begin
    sky_query_t next_q;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (query_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        next_q = query_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.pos_ra <= next_q.ra;
        in_ch.pos_dec <= next_q.dec;
        in_ch.box_ra_low <= next_q.ra_lo;
        in_ch.box_dec_low <= next_q.dec_lo;
        in_ch.box_ra_high <= next_q.ra_hi;
        in_ch.box_dec_high <= next_q.dec_hi;
        in_ch.null_mask <= next_q.nulls;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side backpressure.
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Monitor: checks each verdict transfer, then records the prediction for
  // each query transfer.
  always @(posedge clk) begin
    sky_query_t seen;
    psb_pkg::verdict_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict, expected none, actual %0d", $realtime,
                   out_ch.verdict);
          error_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_ch.verdict !== want) begin
            $display("%0t: verdict mismatch, expected %0d, actual %0d", $realtime,
                     want, out_ch.verdict);
            error_count++;
          end
          case (want)
            psb_pkg::VERDICT_INSIDE:  n_in_box++;
            psb_pkg::VERDICT_OUTSIDE: n_out_box++;
            default:                  n_invalid++;
          endcase
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.ra = in_ch.pos_ra;
        seen.dec = in_ch.pos_dec;
        seen.ra_lo = in_ch.box_ra_low;
        seen.dec_lo = in_ch.box_dec_low;
        seen.ra_hi = in_ch.box_ra_high;
        seen.dec_hi = in_ch.box_dec_high;
        seen.nulls = in_ch.null_mask;
        verdict_q.push_back(predict_verdict(seen));
      end
    end
  end

  // Blocks the sender until every query has been taken and answered. The check
  // runs on the falling edge, after the rising edge updates have settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (query_q.size() != 0 || in_ch.valid || verdict_q.size() != 0);
  endtask

  task automatic run_phase(int s_idle, int r_idle, int count);
    send_idle = s_idle;
    recv_idle = r_idle;
    repeat (count) query_q.push_back(random_query());
    wait_drained();
  endtask

  // Stimulus: directed corner cases, then three paced random phases.
  initial begin
    @(posedge rst_n);
    // Each null flag on its own, over an otherwise inside query.
    for (int i = 0; i < NOPS; i++)
      query_q.push_back(make_query(deg(15), deg(5), deg(10), deg(0), deg(20), deg(10),
                                   1 << i));
    // Declinations just past the poles.
    query_q.push_back(make_query(deg(15), RIGHT_ANGLE + 1, deg(10), deg(0), deg(20),
                                 RIGHT_ANGLE, 0));
    query_q.push_back(make_query(deg(15), deg(5), deg(10), -RIGHT_ANGLE - 1, deg(20),
                                 deg(10), 0));
    query_q.push_back(make_query(deg(15), deg(5), deg(10), deg(0), deg(20),
                                 RIGHT_ANGLE + 1, 0));
    // Reversed right ascension with an endpoint off the circle, and on its edge.
    query_q.push_back(make_query(deg(5), deg(5), deg(20), deg(0), deg(-10), deg(10), 0));
    query_q.push_back(make_query(deg(5), deg(5), FULL_CIRCLE + 1, deg(0), deg(10),
                                 deg(10), 0));
    query_q.push_back(make_query(deg(5), deg(5), FULL_CIRCLE, deg(0), deg(10), deg(10), 0));
    // Empty declination band, and a band that misses the point.
    query_q.push_back(make_query(deg(15), deg(20), deg(10), deg(30), deg(20), deg(10), 0));
    query_q.push_back(make_query(deg(15), deg(40), deg(10), deg(0), deg(20), deg(10), 0));
    // Spans of a full turn or more, and one just short of a turn.
    query_q.push_back(make_query(deg(250), deg(5), deg(-100), deg(0), deg(300), deg(10), 0));
    query_q.push_back(make_query(deg(5), deg(5), deg(10), deg(0), deg(370), deg(10), 0));
    query_q.push_back(make_query(FULL_CIRCLE - 1, deg(5), 0, deg(0), FULL_CIRCLE - 1,
                                 deg(10), 0));
    // Boxes that wrap through zero.
    query_q.push_back(make_query(deg(5), deg(5), deg(350), deg(0), deg(10), deg(10), 0));
    query_q.push_back(make_query(deg(180), deg(5), deg(350), deg(0), deg(10), deg(10), 0));
    query_q.push_back(make_query(deg(355), deg(5), deg(-10), deg(0), deg(10), deg(10), 0));
    // Exact box edges and one step beyond.
    query_q.push_back(make_query(deg(10), deg(0), deg(10), deg(0), deg(20), deg(10), 0));
    query_q.push_back(make_query(deg(20), deg(10), deg(10), deg(0), deg(20), deg(10), 0));
    query_q.push_back(make_query(deg(20) + 1, deg(5), deg(10), deg(0), deg(20), deg(10), 0));
    // Extremes of the angle range.
    query_q.push_back(make_query(ANGLE_MAX, RIGHT_ANGLE, ANGLE_MIN, -RIGHT_ANGLE, ANGLE_MAX,
                                 RIGHT_ANGLE, 0));
    query_q.push_back(make_query(ANGLE_MIN, ANGLE_MIN, ANGLE_MIN, ANGLE_MIN, ANGLE_MIN,
                                 ANGLE_MIN, 0));
    query_q.push_back(make_query(ANGLE_MIN, -RIGHT_ANGLE, 0, -RIGHT_ANGLE, deg(359),
                                 -RIGHT_ANGLE, 0));
    query_q.push_back(make_query(ANGLE_MAX, ANGLE_MAX, ANGLE_MAX, ANGLE_MAX, ANGLE_MAX,
                                 ANGLE_MAX, 63));
    run_phase(18, 58, 470);
    run_phase(58, 18, 470);
    run_phase(0, 0, 470);
    repeat (8) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $display("%0t: %0d verdicts never arrived", $realtime, verdict_q.size());
      error_count++;
    end
    $display("Covered %0d inside, %0d outside and %0d null verdicts across three pacings,",
             n_in_box, n_out_box, n_invalid);
    $display("with %0d mismatches found.", error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/psb_pkg.sv
src/psb_if.sv
src/psb_wrap.sv
src/psb_judge.sv
src/point_in_sky_box.sv
tb/point_in_sky_box_test.sv
